// ----- hdl/daq_pkg.sv -----
// Package for the direction angle quantizer: stage types and tangent table.
`timescale 1ns / 1ps

package daq_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned MagW   = 15;
  localparam int unsigned DvsW   = 10;
  localparam int unsigned QuoW   = 5;
  localparam int unsigned DirW   = 6;
  localparam int unsigned TanW   = 4;

  localparam logic [MagW-1:0] MagMax = 15'h7fff;

  localparam logic [DirW-1:0] DirUp       = 6'd0;
  localparam logic [DirW-1:0] DirUpRight  = 6'd8;
  localparam logic [DirW-1:0] DirRight    = 6'd16;
  localparam logic [DirW-1:0] DirDnRight  = 6'd24;
  localparam logic [DirW-1:0] DirDown     = 6'd32;
  localparam logic [DirW-1:0] DirDnLeft   = 6'd40;
  localparam logic [DirW-1:0] DirLeft     = 6'd48;
  localparam logic [DirW-1:0] DirUpLeft   = 6'd56;

  // Divider stage contents; base +/- tan_step(quo) gives the answer.
  typedef struct packed {
    logic            valid;
    logic            fixed;   // snapped to an axis or exact diagonal
    logic            neg;     // subtract table step from base
    logic [DirW-1:0] base;
    logic            sat;     // quotient clipped to its maximum
    logic [MagW-1:0] rem;
    logic [DvsW-1:0] dvs;
    logic [QuoW-1:0] quo;
  } div_stage_t;

  function automatic logic [TanW-1:0] tan_step(input logic [QuoW-1:0] idx);
    logic [TanW-1:0] t;
    case (idx)
      5'd0, 5'd1:                         t = 4'd0;
      5'd2, 5'd3, 5'd4:                   t = 4'd1;
      5'd5, 5'd6, 5'd7, 5'd8:             t = 4'd2;
      5'd9, 5'd10, 5'd11:                 t = 4'd3;
      5'd12, 5'd13, 5'd14, 5'd15:         t = 4'd4;
      5'd16, 5'd17, 5'd18, 5'd19:         t = 4'd5;
      5'd20, 5'd21, 5'd22, 5'd23:         t = 4'd6;
      5'd24, 5'd25, 5'd26, 5'd27,
      5'd28, 5'd29:                       t = 4'd7;
      default:                            t = 4'd8;
    endcase
    return t;
  endfunction

endpackage

// ----- hdl/direction_angle_quantizer.sv -----
// Each accepted item is registered in every stage listed below before it is
// offered on out_valid_o. One item per cycle while the output is not stalled.
// Stages: wrap differences, octant/snap decode, saturation check plus two
// quotient bits, three quotient bits, tangent lookup and final add.
// The pipeline stalls as a whole only while the output item is not taken.
// Reset (rst_ni low, async) clears the stage valid bits; data is not reset.
`timescale 1ns / 1ps

module direction_angle_quantizer import daq_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [CoordW-1:0] from_x_i,
  input  logic signed [CoordW-1:0] from_y_i,
  input  logic signed [CoordW-1:0] to_x_i,
  input  logic signed [CoordW-1:0] to_y_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [DirW-1:0]          direction_o
);

  // One restoring step: compare remainder against divisor shifted by k.
  function automatic logic [MagW:0] div_step(input logic [MagW-1:0] rem,
                                             input logic [DvsW-1:0] dvs,
                                             input int unsigned     k);
    logic [MagW-1:0] sh;
    logic            ge;
    sh = MagW'(dvs) << k;
    ge = (rem >= sh);
    return {ge, ge ? rem - sh : rem};
  endfunction

  function automatic logic [MagW-1:0] mag_sat(input logic [CoordW-1:0] v);
    logic [CoordW-1:0] m;
    m = v[CoordW-1] ? (~v + CoordW'(1)) : v;
    return m[CoordW-1] ? MagMax : m[MagW-1:0];
  endfunction

  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // Stage 1: wrapped differences
  logic                     v1_q;
  logic signed [CoordW-1:0] dx_q, dy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q <= to_x_i - from_x_i;
      dy_q <= to_y_i - from_y_i;
    end
  end

  // Stage 2: snap, octant and operand selection
  div_stage_t s2_d, s2_q;
  logic [MagW-1:0] ax, ay;
  logic snap_x, snap_y, dx_pos, dy_pos, dy_neg, y_major, diag;

  always_comb begin
    ax      = mag_sat(dx_q);
    ay      = mag_sat(dy_q);
    snap_x  = (dx_q >= -16'sd31) && (dx_q <= 16'sd31);
    snap_y  = (dy_q >= -16'sd31) && (dy_q <= 16'sd31);
    dx_pos  = (dx_q > 16'sd0);
    dy_pos  = (dy_q > 16'sd0);
    dy_neg  = dy_q[CoordW-1];
    y_major = (ay > ax);
    diag    = (ax == ay);

    s2_d       = '0;
    s2_d.valid = v1_q;
    s2_d.rem   = y_major ? ax : ay;
    s2_d.dvs   = y_major ? ay[MagW-1:MagW-DvsW] : ax[MagW-1:MagW-DvsW];

    if (snap_x) begin
      s2_d.fixed = 1'b1;
      s2_d.base  = dy_pos ? DirDown : DirUp;
    end else if (snap_y) begin
      s2_d.fixed = 1'b1;
      s2_d.base  = dx_pos ? DirRight : DirLeft;
    end else if (dx_pos && dy_neg) begin
      s2_d.fixed = diag;
      s2_d.neg   = !y_major;
      s2_d.base  = diag ? DirUpRight : (y_major ? DirUp : DirRight);
    end else if (dx_pos) begin
      s2_d.fixed = diag;
      s2_d.neg   = y_major;
      s2_d.base  = diag ? DirDnRight : (y_major ? DirDown : DirRight);
    end else if (dy_pos) begin
      s2_d.fixed = diag;
      s2_d.neg   = !y_major;
      s2_d.base  = diag ? DirDnLeft : (y_major ? DirDown : DirLeft);
    end else begin
      s2_d.fixed = diag;
      s2_d.neg   = y_major;
      // up-left, y major: 64 - t wraps to base 0 minus t
      s2_d.base  = diag ? DirUpLeft : (y_major ? DirUp : DirLeft);
    end
  end

  // Stage 3: saturation check and quotient bits 4..3
  div_stage_t s3_d, s3_q;
  logic [MagW:0] st4, st3;

  always_comb begin
    s3_d = s2_q;
    st4  = '0;
    st3  = '0;
    if (div_step(s2_q.rem, s2_q.dvs, QuoW) >> MagW != '0) begin
      s3_d.sat = 1'b1;
      s3_d.quo = '1;
    end else begin
      st4         = div_step(s2_q.rem, s2_q.dvs, 4);
      st3         = div_step(st4[MagW-1:0], s2_q.dvs, 3);
      s3_d.quo[4] = st4[MagW];
      s3_d.quo[3] = st3[MagW];
      s3_d.rem    = st3[MagW-1:0];
    end
  end

  // Stage 4: quotient bits 2..0
  div_stage_t s4_d, s4_q;
  logic [MagW:0] st2, st1, st0;

  always_comb begin
    s4_d = s3_q;
    st2  = div_step(s3_q.rem, s3_q.dvs, 2);
    st1  = div_step(st2[MagW-1:0], s3_q.dvs, 1);
    st0  = div_step(st1[MagW-1:0], s3_q.dvs, 0);
    if (!s3_q.sat) begin
      s4_d.quo[2] = st2[MagW];
      s4_d.quo[1] = st1[MagW];
      s4_d.quo[0] = st0[MagW];
      s4_d.rem    = st0[MagW-1:0];
    end
  end

  // Stage 5: table lookup and final add/subtract
  logic [DirW-1:0] tstep, dir_d, dir_q;
  logic            v5_q;

  always_comb begin
    tstep = s4_q.fixed ? '0 : DirW'(tan_step(s4_q.quo));
    dir_d = s4_q.neg ? s4_q.base - tstep : s4_q.base + tstep;
  end

  // only the valid bits see reset; data fields just follow the enable
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q.valid <= 1'b0;
      s3_q.valid <= 1'b0;
      s4_q.valid <= 1'b0;
      v5_q       <= 1'b0;
    end else if (en) begin
      s2_q       <= s2_d;
      s3_q       <= s3_d;
      s4_q       <= s4_d;
      v5_q       <= s4_q.valid;
      dir_q      <= dir_d;
    end
  end

  assign out_valid_o = v5_q;
  assign direction_o = dir_q;

`ifndef SYNTHESIS
  a_stall_only_on_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  a_item_reaches_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && s4_q.valid |=> out_valid_o)
    else $error("item lost between last stage and output");

  a_sat_quotient_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_q.valid && s3_q.sat |-> s3_q.quo == '1)
    else $error("saturated quotient not at maximum");

  a_fixed_passes_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && s4_q.valid && s4_q.fixed |=> direction_o == $past(s4_q.base))
    else $error("snapped direction altered by table step");
`endif

endmodule

// ----- tb/direction_checker.sv -----
// Checker for the direction quantizer: predicts each heading and compares results.
`timescale 1ns / 1ps

module direction_checker import daq_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic signed [CoordW-1:0] from_x_i,
  input  logic signed [CoordW-1:0] from_y_i,
  input  logic signed [CoordW-1:0] to_x_i,
  input  logic signed [CoordW-1:0] to_y_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic [DirW-1:0]          direction_i,
  output int                       mismatches_o,
  output int                       pending_o
);

  // Tangent steps indexed by small / (large / 32), entry 31 first.
  localparam logic [31:0][3:0] TanSteps = {
    4'd8, 4'd8,
    4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7,
    4'd6, 4'd6, 4'd6, 4'd6,
    4'd5, 4'd5, 4'd5, 4'd5,
    4'd4, 4'd4, 4'd4, 4'd4,
    4'd3, 4'd3, 4'd3,
    4'd2, 4'd2, 4'd2, 4'd2,
    4'd1, 4'd1, 4'd1,
    4'd0, 4'd0
  };

  logic [DirW-1:0] heading_q [$];

  function automatic logic [DirW-1:0] tan_offset(input int minor, input int major);
    int div;
    int idx;
    div = major / 32;
    if (div == 0) return '0;
    idx = minor / div;
    if (idx > 31) idx = 31;
    return DirW'(TanSteps[idx[4:0]]);
  endfunction

  function automatic logic [DirW-1:0] expected_heading(
    input logic [CoordW-1:0] fx,
    input logic [CoordW-1:0] fy,
    input logic [CoordW-1:0] tx,
    input logic [CoordW-1:0] ty
  );
    logic signed [CoordW-1:0] dx;
    logic signed [CoordW-1:0] dy;
    int sx;
    int sy;
    int ax;
    int ay;
    dx = tx - fx;
    dy = ty - fy;
    sx = dx;
    sy = dy;
    // x axis snap wins over y axis snap
    if (sx <= 31 && sx >= -31) return (sy > 0) ? DirDown : DirUp;
    if (sy <= 31 && sy >= -31) return (sx > 0) ? DirRight : DirLeft;
    ax = (sx < 0) ? -sx : sx;
    ay = (sy < 0) ? -sy : sy;
    if (ax > 32767) ax = 32767;
    if (ay > 32767) ay = 32767;
    if (sx > 0) begin
      if (sy < 0) begin
        if (ax == ay) return DirUpRight;
        if (ay > ax) return DirUp + tan_offset(ax, ay);
        return DirRight - tan_offset(ay, ax);
      end
      if (ax == ay) return DirDnRight;
      if (ay > ax) return DirDown - tan_offset(ax, ay);
      return DirRight + tan_offset(ay, ax);
    end
    if (sy > 0) begin
      if (ax == ay) return DirDnLeft;
      if (ay > ax) return DirDown + tan_offset(ax, ay);
      return DirLeft - tan_offset(ay, ax);
    end
    if (ax == ay) return DirUpLeft;
    if (ay > ax) return DirUp - tan_offset(ax, ay);
    return DirLeft + tan_offset(ay, ax);
  endfunction

  always @(posedge clk_i) begin
    logic [DirW-1:0] want;
    int errs;
    errs = mismatches_o;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        heading_q.push_back(expected_heading(from_x_i, from_y_i, to_x_i, to_y_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (heading_q.size() == 0) begin
          $display("%0t: unexpected item: expected none, actual direction %0d",
                   $time, direction_i);
          errs++;
        end else begin
          want = heading_q.pop_front();
          if (direction_i !== want) begin
            $display("%0t: direction mismatch: expected %0d, actual %0d",
                     $time, want, direction_i);
            errs++;
          end
        end
      end
    end
    mismatches_o <= errs;
    pending_o    <= heading_q.size();
  end

endmodule

// ----- tb/testbench.sv -----
// Top of the direction quantizer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
  import daq_pkg::*;

  localparam int RandomItems = 1425;
  localparam int CalmFrom    = 1225;
  localparam int HoldAt      = 120;
  localparam int HoldCycles  = 48;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_ready_o;
  logic signed [CoordW-1:0] from_x_i    = '0;
  logic signed [CoordW-1:0] from_y_i    = '0;
  logic signed [CoordW-1:0] to_x_i      = '0;
  logic signed [CoordW-1:0] to_y_i      = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic [DirW-1:0]          direction_o;

  int mismatches;
  int pending;
  int items_sent = 0;
  bit calm       = 1'b0;
  bit held       = 1'b0;

  direction_angle_quantizer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .from_x_i    (from_x_i),
    .from_y_i    (from_y_i),
    .to_x_i      (to_x_i),
    .to_y_i      (to_y_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .direction_o (direction_o)
  );

  direction_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .from_x_i     (from_x_i),
    .from_y_i     (from_y_i),
    .to_x_i       (to_x_i),
    .to_y_i       (to_y_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .direction_i  (direction_o),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Offer one point pair; returns at the edge where it is accepted.
  task automatic send_pair(input logic [CoordW-1:0] fx, input logic [CoordW-1:0] fy,
                           input logic [CoordW-1:0] tx, input logic [CoordW-1:0] ty);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    from_x_i   <= fx;
    from_y_i   <= fy;
    to_x_i     <= tx;
    to_y_i     <= ty;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_delta(input logic [CoordW-1:0] fx, input logic [CoordW-1:0] fy,
                            input int ddx, input int ddy);
    logic [CoordW-1:0] tx;
    logic [CoordW-1:0] ty;
    tx = fx + CoordW'(ddx);
    ty = fy + CoordW'(ddy);
    send_pair(fx, fy, tx, ty);
  endtask

  task automatic send_random_pair();
    logic [CoordW-1:0] fx;
    logic [CoordW-1:0] fy;
    int ddx;
    int ddy;
    int m;
    int k;
    fx = CoordW'($urandom);
    fy = CoordW'($urandom);
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        ddx = $urandom_range(0, 65535);
        ddy = $urandom_range(0, 65535);
      end
      3: begin
        // near an axis: one difference around the snap bound
        ddx = $urandom_range(0, 80) - 40;
        ddy = $urandom_range(0, 65535);
        if ($urandom_range(0, 1)) begin
          m = ddx; ddx = ddy; ddy = m;
        end
      end
      4, 5: begin
        ddx = $urandom_range(32, 200);
        ddy = $urandom_range(32, 200);
        if ($urandom_range(0, 1)) ddx = -ddx;
        if ($urandom_range(0, 1)) ddy = -ddy;
      end
      6: begin
        // close to a diagonal
        m   = $urandom_range(32, 32767);
        ddx = $urandom_range(0, 1) ? m : -m;
        ddy = m + $urandom_range(0, 6) - 3;
        if ($urandom_range(0, 1)) ddy = -ddy;
      end
      7: begin
        ddx = -32768;
        ddy = $urandom_range(0, 65535);
        if ($urandom_range(0, 1)) begin
          m = ddx; ddx = ddy; ddy = m;
        end
      end
      default: begin
        k   = $urandom_range(5, 15);
        ddx = $urandom_range(0, (1 << k) - 1) - (1 << (k - 1));
        k   = $urandom_range(5, 15);
        ddy = $urandom_range(0, (1 << k) - 1) - (1 << (k - 1));
      end
    endcase
    send_delta(fx, fy, ddx, ddy);
  endtask

  // Receiver: random stalls, one long hold-off so the pipeline backs up.
  initial begin
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (!held && items_sent >= HoldAt) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // axis snaps, diagonals, octants and corner values
    send_pair(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_pair(16'sd0, 16'sd0, 16'sd0, 16'sd100);
    send_pair(16'sd0, 16'sd0, 16'sd31, -16'sd5000);
    send_pair(16'sd0, 16'sd0, -16'sd31, 16'sd5000);
    send_pair(16'sd0, 16'sd0, 16'sd5000, 16'sd31);
    send_pair(16'sd0, 16'sd0, -16'sd5000, -16'sd31);
    send_pair(16'sd0, 16'sd0, 16'sd100, -16'sd100);
    send_pair(16'sd0, 16'sd0, 16'sd100, 16'sd100);
    send_pair(16'sd0, 16'sd0, -16'sd100, 16'sd100);
    send_pair(16'sd0, 16'sd0, -16'sd100, -16'sd100);
    send_pair(16'sd0, 16'sd0, 16'sd32, -16'sd1000);
    send_pair(16'sd0, 16'sd0, 16'sd1000, -16'sd32);
    send_pair(16'sd0, 16'sd0, 16'sd1000, 16'sd40);
    send_pair(16'sd0, 16'sd0, 16'sd40, 16'sd1000);
    send_pair(16'sd0, 16'sd0, -16'sd40, 16'sd1000);
    send_pair(16'sd0, 16'sd0, -16'sd1000, 16'sd40);
    send_pair(16'sd0, 16'sd0, -16'sd1000, -16'sd40);
    send_pair(16'sd0, 16'sd0, -16'sd40, -16'sd1000);
    // differences of -32768 saturate in magnitude
    send_pair(16'sd0, 16'sd0, 16'h8000, 16'h8000);
    send_pair(16'sd0, 16'sd0, 16'h8000, 16'sd100);
    send_pair(16'h0000, 16'h8000, 16'h7fff, 16'h0000);
    send_pair(16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    send_pair(16'hffff, 16'hffff, 16'h8000, 16'h0000);
    // table index past the end clips
    send_pair(16'sd0, 16'sd0, 16'sd63, -16'sd62);
    send_pair(16'sd0, 16'sd0, -16'sd62, 16'sd63);

    for (int i = 0; i < RandomItems; i++) begin
      if (i == CalmFrom) calm = 1'b1;
      send_random_pair();
    end
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
